/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the xorshift128+ generator.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

/* rtl/xsp_pkg.sv */
// Shared types, codes and constants of the xorshift128+ generator with splitmix64 seeding.
// No dependencies; every other RTL module imports this package.
package xsp_pkg;

    // Operation codes of an input word.
    localparam logic OP_NEXT   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Output reduction modes.
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_HALF  = 2'd1;
    localparam logic [1:0] MODE_LOW31 = 2'd2;

    // Register index of output_mode, decoded from paddr[2].
    localparam logic REG_OUTPUT_MODE = 1'b0;

    // splitmix64 constants.
    localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    localparam logic [63:0] LOW31_MASK = 64'h0000_0000_7fff_ffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREMIX,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MIDMIX,
        ST_STORE
    } state_t;

    // Steps of the 64x64 (low half) multiply on one 32x32 multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LL,
        MUL_HL,
        MUL_LH,
        MUL_ACC
    } mul_step_t;

    typedef struct packed {
        logic      next_item;
        logic      reseed_load;
        logic      premix;
        mul_step_t mul_step;
        logic      const_sel;
        logic      midmix;
        logic      store_first;
        logic      store_second;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

/* rtl/xorshift128plus_splitmix_generator_top.sv */
// xorshift128+ generator with splitmix64 seeding; top level, uses all rtl modules and xsp_pkg.
// Latency: a next word is accepted and its result enters the output queue in the following cycle.
// Throughput: one next word per cycle while the output queue has room; a reseed word holds the
// input stalled while the splitmix64 mixer reuses one 32x32 multiplier for four 64-bit multiplies.
// Reset (rst_n, asynchronous, active low) clears both state words, output_mode and the
// output queue; the generator gives zeros until it is reseeded.
`include "assert_macros.svh"

module xorshift128plus_splitmix_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] seed_value,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_value
);
    import xsp_pkg::*;

    // Only one register exists, so a single address bit (byte address 0) decodes it;
    // the low two bits address bytes inside the word and are ignored.
    logic [1:0] mode_reg;
    logic       cfg_write;

    ctrl_cmd_t   cmd;
    fifo_stat_t  fifo_stat;
    logic        push;
    logic [63:0] push_data;

    // Handshake terms used by the assertions below.
    logic        in_accept;
    logic        low31_arm;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RAW;
        end
        else if (cfg_write && paddr[2] == REG_OUTPUT_MODE)
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    // Reads of addresses beyond the register list return zero.
    assign prdata = (paddr[2] == REG_OUTPUT_MODE) ? {30'd0, mode_reg} : 32'd0;

    // The controller accepts a word only in its idle state with room in the queue,
    // and steps the datapath through the two splitmix64 rounds of a reseed.
    xsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .fifo_stat (fifo_stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // The datapath computes the reduced sum and advances the state in the accept cycle.
    xsp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .output_mode (mode_reg),
        .seed_value  (seed_value),
        .push        (push),
        .push_data   (push_data)
    );

    // The two-entry queue lets a new word be accepted while a result waits.
    xsp_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .random_value (random_value),
        .fifo_stat    (fifo_stat)
    );

    assign in_accept = in_valid && !in_stall;
    assign low31_arm = in_accept && operation == OP_NEXT && fifo_stat.empty
                       && mode_reg == MODE_LOW31;

    // A reseed keeps the input stalled while the mixer runs.
    `ASSERT_NEXT(a_reseed_busy, in_accept && operation == OP_RESEED, in_stall)
    // Every accepted next word leaves a result in the queue.
    `ASSERT_NEXT(a_next_gives_result, in_accept && operation == OP_NEXT, out_valid)
    // In low-31 mode a result entering an empty queue shows no high bits.
    `ASSERT_NEXT(a_low31_clean, low31_arm, random_value[63:31] == 33'd0)
    // The datapath pushes only when the queue has room.
    `ASSERT_SAME(a_no_overflow, push, !fifo_stat.full)

endmodule

/* rtl/xsp_ctrl.sv */
// Controller state machine: input handshake and the reseed sequence.
// Depends on xsp_pkg; drives the datapath through a ctrl_cmd_t.
module xsp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               operation,
    input  xsp_pkg::fifo_stat_t fifo_stat,
    output logic               in_stall,
    output xsp_pkg::ctrl_cmd_t cmd
);
    import xsp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   pass_reg;
    logic   pass_next;
    logic   word_reg;
    logic   word_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE) || fifo_stat.full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
            word_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            word_reg  <= word_next;
        end
    end

    // Next state. pass selects the splitmix multiplier, word the target state word.
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        word_next  = word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_RESEED)
                begin
                    state_next = ST_PREMIX;
                    pass_next  = 1'b0;
                    word_next  = 1'b0;
                end
            end
            ST_PREMIX: state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = pass_reg ? ST_STORE : ST_MIDMIX;
            ST_MIDMIX:
            begin
                state_next = ST_MUL0;
                pass_next  = 1'b1;
            end
            ST_STORE:
            begin
                pass_next  = 1'b0;
                word_next  = 1'b1;
                state_next = word_reg ? ST_IDLE : ST_PREMIX;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.mul_step  = MUL_NONE;
        cmd.const_sel = pass_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.next_item   = (operation == OP_NEXT);
                    cmd.reseed_load = (operation == OP_RESEED);
                end
            end
            ST_PREMIX: cmd.premix   = 1'b1;
            ST_MUL0:   cmd.mul_step = MUL_LL;
            ST_MUL1:   cmd.mul_step = MUL_HL;
            ST_MUL2:   cmd.mul_step = MUL_LH;
            ST_MUL3:   cmd.mul_step = MUL_ACC;
            ST_MIDMIX: cmd.midmix   = 1'b1;
            ST_STORE:
            begin
                cmd.store_first  = !word_reg;
                cmd.store_second = word_reg;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* rtl/xsp_datapath.sv */
// Datapath: the two state words, the xorshift128+ step and the splitmix64 mixer
// built around one shared 32x32 multiplier. Depends on xsp_pkg.
module xsp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  xsp_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]         output_mode,
    input  logic [63:0]        seed_value,
    output logic               push,
    output logic [63:0]        push_data
);
    import xsp_pkg::*;

    logic [63:0] first_reg;
    logic [63:0] first_next;
    logic [63:0] second_reg;
    logic [63:0] second_next;
    logic [63:0] z_reg;
    logic [63:0] x_reg;
    logic [63:0] mul_reg;
    logic [63:0] acc_reg;

    logic [63:0] sum;
    logic [63:0] shifted_a;
    logic [63:0] mix_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [63:0] acc_plus;
    logic [63:0] final_mix;

    assign sum       = first_reg + second_reg;
    assign shifted_a = first_reg ^ (first_reg << 23);

    always_comb
    begin
        case (output_mode)
            MODE_HALF:  push_data = sum >> 1;
            MODE_LOW31: push_data = sum & LOW31_MASK;
            default:    push_data = sum;
        endcase
    end
    assign push = cmd.next_item;

    // Low 64 bits of x * k = xL*kL + ((xH*kL + xL*kH) << 32).
    // Both factors are 32-bit values widened to hold the full product.
    assign mix_const = cmd.const_sel ? SM_MUL2 : SM_MUL1;
    assign mul_a     = (cmd.mul_step == MUL_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b     = (cmd.mul_step == MUL_LH) ? mix_const[63:32] : mix_const[31:0];
    assign product   = 64'(mul_a) * 64'(mul_b);
    assign acc_plus  = acc_reg + {mul_reg[31:0], 32'h0000_0000};
    assign final_mix = acc_reg ^ (acc_reg >> 31);

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        if (cmd.next_item)
        begin
            first_next  = second_reg;
            second_next = shifted_a ^ second_reg ^ (shifted_a >> 18) ^ (second_reg >> 5);
        end
        else if (cmd.store_first)
        begin
            first_next = final_mix;
        end
        else if (cmd.store_second)
        begin
            second_next = final_mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Seeding scratch registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.reseed_load)
        begin
            z_reg <= seed_value + SM_GAMMA;
        end
        else if (cmd.store_first || cmd.store_second)
        begin
            z_reg <= z_reg + SM_GAMMA;
        end

        if (cmd.premix)
        begin
            x_reg <= z_reg ^ (z_reg >> 30);
        end
        else if (cmd.midmix)
        begin
            x_reg <= acc_reg ^ (acc_reg >> 27);
        end

        case (cmd.mul_step)
            MUL_LL:
            begin
                mul_reg <= product;
            end
            MUL_HL:
            begin
                acc_reg <= mul_reg;
                mul_reg <= product;
            end
            MUL_LH:
            begin
                acc_reg <= acc_plus;
                mul_reg <= product;
            end
            MUL_ACC:
            begin
                acc_reg <= acc_plus;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

/* rtl/xsp_out_fifo.sv */
// Two-entry output queue between the datapath and the result channel.
// Depends on xsp_pkg for its status struct.
module xsp_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [63:0]         push_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [63:0]         random_value,
    output xsp_pkg::fifo_stat_t fifo_stat
);
    import xsp_pkg::*;

    logic [63:0] entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign out_valid       = (count_reg != 2'd0);
    assign random_value    = entry_reg[rd_ptr_reg];
    assign pop             = out_valid && !out_stall;
    assign fifo_stat.full  = (count_reg == 2'd2);
    assign fifo_stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sim/xsp_result_checker.sv */
// Checker for the xorshift128+ generator: watches the configuration port and both word channels.
// Keeps its own copy of the generator state, predicts every result word and compares it.
// Depends on xsp_pkg for operation codes, output modes and the splitmix64 constants.
module xsp_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [63:0] seed_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] random_value,
    output int          mismatches,
    output int          waiting
);
    import xsp_pkg::*;

    logic [63:0] lead_word = '0;
    logic [63:0] trail_word = '0;
    logic [1:0]  mode_reg = MODE_RAW;
    logic [63:0] expected_words[$];
    int          fail_count = 0;
    int          queued = 0;

    assign mismatches = fail_count;
    assign waiting = queued;

    // Finalizer of splitmix64, applied to an already advanced seed.
    function automatic logic [63:0] splitmix_finish(input logic [63:0] z);
        logic [63:0] t;
        t = (z ^ (z >> 30)) * SM_MUL1;
        t = (t ^ (t >> 27)) * SM_MUL2;
        return t ^ (t >> 31);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sum;
        logic [63:0] want;
        if (!rst_n)
        begin
            lead_word  <= '0;
            trail_word <= '0;
            mode_reg   <= MODE_RAW;
            expected_words.delete();
            queued     <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_OUTPUT_MODE)
                        mode_reg <= pwdata[1:0];
                end
                else if (paddr[2] == REG_OUTPUT_MODE && prdata !== {30'd0, mode_reg})
                begin
                    report_mismatch("output_mode readback", {32'd0, prdata},
                                    {62'd0, mode_reg});
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", random_value, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_value !== want)
                        report_mismatch("random_value", random_value, want);
                end
            end

            if (in_valid && !in_stall)
            begin
                if (operation == OP_RESEED)
                begin
                    lead_word  <= splitmix_finish(seed_value + SM_GAMMA);
                    trail_word <= splitmix_finish(seed_value + SM_GAMMA + SM_GAMMA);
                end
                else
                begin
                    a   = lead_word;
                    b   = trail_word;
                    sum = a + b;
                    a   = a ^ (a << 23);
                    lead_word  <= b;
                    trail_word <= a ^ b ^ (a >> 18) ^ (b >> 5);
                    case (mode_reg)
                        MODE_HALF:  want = sum >> 1;
                        MODE_LOW31: want = sum & LOW31_MASK;
                        default:    want = sum;
                    endcase
                    expected_words.push_back(want);
                end
            end

            queued <= expected_words.size();
        end
    end

endmodule

/* sim/tb_xorshift128plus_splitmix_generator_top.sv */
// Testbench top for the xorshift128+ generator: makes stimulus and gives the verdict.
// Depends on xsp_pkg, the generator RTL and xsp_result_checker, which does all checking.
module tb_xorshift128plus_splitmix_generator_top;
    import xsp_pkg::*;

    // The slowest correct run stays well under this limit: every word can meet an idle
    // burst and a receiver stall, and a reseed keeps the input stalled while it mixes.
    localparam int CYCLE_LIMIT     = 300000;
    // A reseed word may still be mixing after the last result word has come.
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 120;

    // Register addresses: output_mode, and one slot that decodes to no register.
    localparam logic [2:0] ADDR_OUTPUT_MODE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
    // The mode code left unused by the design; it must act as the raw mode.
    localparam logic [1:0] MODE_UNUSED      = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_NEXT;
    logic [63:0] seed_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] random_value;

    int   mismatches;
    int   waiting;
    int   cycle_count = 0;
    // Set for the last phase: neither side idles any more.
    logic calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    xorshift128plus_splitmix_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    xsp_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    // Watchdog: a run that hangs on a missing word or a stuck stall ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL xorshift128plus_splitmix_generator_top");
            $finish;
        end
    end

    // All tasks below are entered just after a rising edge and return just after one,
    // so every drive is a single nonblocking assignment at a rising edge.

    // One APB transfer: a setup phase, then the access phase held until pready,
    // then an idle phase so that transfers in a row never drive psel twice at once.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one word and waits for the edge that accepts it. Valid stays high
    // afterwards, so back-to-back words never drop it in between.
    task automatic send_word(input logic op, input logic [63:0] seed);
        in_valid   <= 1'b1;
        operation  <= op;
        seed_value <= seed;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted word has come out. The count is read
    // only after a further edge, so that a word accepted at the current edge is already counted.
    // The settle time then covers a reseed still mixing inside the block.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Changes the output mode with the block idle. A write to the unmapped slot with
    // random data must leave the mode alone, which the readback then confirms.
    task automatic set_mode(input logic [1:0] mode);
        logic [31:0] noise;
        noise = $urandom;
        drain();
        apb_access(1'b1, ADDR_OUTPUT_MODE, {noise[31:2], mode});
        apb_access(1'b1, ADDR_UNMAPPED, $urandom);
        apb_access(1'b0, ADDR_OUTPUT_MODE, '0);
    endtask

    // A phase of random words: mostly next-number words, with a reseed now and then
    // so that the state is restarted from many seeds, extremes among them. Next words
    // carry random seed bits too, which the block has to ignore.
    task automatic run_phase(input logic [1:0] mode, input int count);
        logic        op;
        logic [63:0] seed;
        set_mode(mode);
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 15) == 0) ? OP_RESEED : OP_NEXT;
            case ($urandom_range(0, 15))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = {$urandom, $urandom};
            endcase
            send_word(op, seed);
            if (!calm && $urandom_range(0, 7) == 0)
                idle_gap();
        end
    endtask

    // The receiver stalls in random bursts and runs free for random stretches, so
    // stalls land on every phase of a reseed and of back-to-back next words.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [1:0] phase_mode[RANDOM_PHASES];
        phase_mode[0] = MODE_HALF;
        phase_mode[1] = MODE_LOW31;
        phase_mode[2] = MODE_UNUSED;
        phase_mode[3] = MODE_RAW;
        phase_mode[4] = 2'($urandom_range(0, 3));
        phase_mode[5] = MODE_LOW31;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Raw mode written explicitly, then read back.
        apb_access(1'b1, ADDR_OUTPUT_MODE, {30'd0, MODE_RAW});
        apb_access(1'b0, ADDR_OUTPUT_MODE, '0);

        // Before any seeding the state is all zero: next words give zero and the
        // state stays zero. The seed bits of these words are ignored.
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '1);
        // Seeds at the extremes of the field, all but the last followed by a few numbers.
        send_word(OP_RESEED, '0);
        send_word(OP_NEXT, {$urandom, $urandom});
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '1);
        send_word(OP_RESEED, '1);
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '0);
        send_word(OP_RESEED, 64'h8000_0000_0000_0000);
        send_word(OP_NEXT, '0);
        send_word(OP_RESEED, 64'h0000_0000_0000_0001);
        // Two more reseeds in a row: only the last one must count.
        send_word(OP_RESEED, 64'h0000_0000_0000_0001);
        send_word(OP_RESEED, {$urandom, $urandom});
        send_word(OP_NEXT, '0);
        send_word(OP_NEXT, '1);
        send_word(OP_NEXT, '0);

        // Random phases under changing modes; the mode change between phases makes
        // the sender pause until every expected word has come out.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            run_phase(phase_mode[p], WORDS_PER_PHASE);
        end

        drain();
        if (mismatches == 0)
            $display("PASS xorshift128plus_splitmix_generator_top");
        else
            $display("FAIL xorshift128plus_splitmix_generator_top");
        $finish;
    end

endmodule
